### rtl/core/hrss_pkg.sv
// Shared types, constants, saturation and cell-count clamp helpers for the heat rod stencil stepper.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps
`default_nettype none

package hrss_pkg;

    localparam int MAX_CELLS = 64;
    localparam int TEMP_BITS = 24;

    localparam int CNT_W = $clog2(MAX_CELLS);
    localparam int N_W   = CNT_W + 1;

    // Fixed field widths of the register file and the result item
    localparam int CELLS_W = 7;
    localparam int COND_W  = 9;
    localparam int TFLD_W  = 24;
    localparam int POS_W   = 6;
    localparam int STEP_W  = 16;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int S_TD_W  = 8;
    localparam int M_TD_W  = 48;

    localparam int SAT_W = ((TEMP_BITS > TFLD_W) ? TEMP_BITS : TFLD_W) + 4;

    typedef logic signed [TEMP_BITS-1:0] t_temp;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_CELLS = 3'd0;
    localparam logic [2:0] REG_COND  = 3'd1;
    localparam logic [2:0] REG_START = 3'd2;
    localparam logic [2:0] REG_LEFT  = 3'd3;
    localparam logic [2:0] REG_RIGHT = 3'd4;

    // Reset values of the registers
    localparam logic [CELLS_W-1:0]       RST_CELLS = 7'd32;
    localparam logic [COND_W-1:0]        RST_COND  = 9'd128;
    localparam logic signed [TFLD_W-1:0] RST_START = 24'sd12800;
    localparam logic signed [TFLD_W-1:0] RST_LEFT  = 24'sd5120;
    localparam logic signed [TFLD_W-1:0] RST_RIGHT = 24'sd2560;

    localparam logic [COND_W-1:0] K_MAX = 9'd256;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((64'sd1 <<< (TEMP_BITS - 1)) - 64'sd1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    typedef struct packed {
        logic [CELLS_W-1:0]       cells;
        logic [COND_W-1:0]        cond;
        logic signed [TFLD_W-1:0] start;
        logic signed [TFLD_W-1:0] left;
        logic signed [TFLD_W-1:0] right;
    } t_cfg;

    typedef struct packed {
        logic shift;
        logic load;
        logic update;
    } t_cell_ctl;

    function automatic t_temp sat_temp(input logic signed [SAT_W-1:0] v);
        t_temp res;
        if (v > SAT_HI) begin
            res = t_temp'(SAT_HI);
        end else if (v < SAT_LO) begin
            res = t_temp'(SAT_LO);
        end else begin
            res = t_temp'(v);
        end
        return res;
    endfunction

    // Clamp the cell count register into [3, MAX_CELLS]
    function automatic logic [N_W-1:0] eff_cells(input logic [CELLS_W-1:0] c);
        logic [N_W-1:0] res;
        if (c < CELLS_W'(3)) begin
            res = N_W'(3);
        end else if (c > CELLS_W'(MAX_CELLS)) begin
            res = N_W'(MAX_CELLS);
        end else begin
            res = N_W'(c);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/core/hrss_cfg.sv
// APB-style register file: cell count, conductivity and the three load temperatures.
// Depends on hrss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrss_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hrss_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [hrss_pkg::DATA_W-1:0]   pwdata,
    output logic      [hrss_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output hrss_pkg::t_cfg                     o_cfg
);
    import hrss_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cells <= RST_CELLS;
            r_cfg.cond  <= RST_COND;
            r_cfg.start <= RST_START;
            r_cfg.left  <= RST_LEFT;
            r_cfg.right <= RST_RIGHT;
        end else if (w_wr) begin
            case (w_idx)
                REG_CELLS: r_cfg.cells <= pwdata[CELLS_W-1:0];
                REG_COND:  r_cfg.cond  <= pwdata[COND_W-1:0];
                REG_START: r_cfg.start <= pwdata[TFLD_W-1:0];
                REG_LEFT:  r_cfg.left  <= pwdata[TFLD_W-1:0];
                REG_RIGHT: r_cfg.right <= pwdata[TFLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CELLS: prdata = DATA_W'(r_cfg.cells);
            REG_COND:  prdata = DATA_W'(r_cfg.cond);
            REG_START: prdata = DATA_W'(unsigned'(r_cfg.start));
            REG_LEFT:  prdata = DATA_W'(unsigned'(r_cfg.left));
            REG_RIGHT: prdata = DATA_W'(unsigned'(r_cfg.right));
            default:   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/hrss_cell.sv
// One rod cell: holds a temperature, shifts it toward its left neighbor and
// computes its own stencil update. Depends on hrss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrss_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire hrss_pkg::t_cell_ctl           i_ctl,
    input  wire logic                          i_inner,
    input  wire logic [hrss_pkg::COND_W-1:0]   i_k,
    input  wire hrss_pkg::t_temp               i_load_val,
    input  wire hrss_pkg::t_temp               i_prev,
    input  wire hrss_pkg::t_temp               i_next,
    output hrss_pkg::t_temp                    o_temp
);
    import hrss_pkg::*;

    localparam int D_W = TEMP_BITS + 2;
    localparam int P_W = D_W + COND_W + 1;

    t_temp                  r_temp;
    logic signed [D_W-1:0]  w_diff;
    logic signed [P_W-1:0]  w_prod;
    logic signed [P_W-1:0]  w_wide;
    t_temp                  w_upd;

    // 2*own - left - right, then own*256 - k*diff + 1/2 LSB
    assign w_diff = (D_W'(r_temp) <<< 1) - D_W'(i_prev) - D_W'(i_next);
    assign w_prod = $signed({1'b0, i_k}) * w_diff;
    assign w_wide = (P_W'(r_temp) <<< 8) - w_prod + P_W'(128);
    assign w_upd  = sat_temp(SAT_W'($signed(w_wide[P_W-1:8])));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp <= i_load_val;
        end else if (i_ctl.load) begin
            r_temp <= i_load_val;
        end else if (i_ctl.shift) begin
            r_temp <= i_next;
        end else if (i_ctl.update && i_inner) begin
            r_temp <= w_upd;
        end
    end

    assign o_temp = r_temp;

endmodule

`default_nettype wire

### rtl/core/heat_rod_stencil_stepper.sv
// Top level of the heat rod stencil stepper: stream ports, sequencer and the cell chain.
// Depends on hrss_pkg, hrss_cfg and hrss_cell.
`timescale 1ns / 1ps
`default_nettype none

// Explicit 1-D heat equation, one time step per input item. The rod is a ring of
// MAX_CELLS (64) cells; each item first reloads the initial row if restart is set
// (left end, start value inside, right end at cell n-1, step counter zeroed), then
// rotates the whole ring once, emitting cell 0 of the ring as cells 0 to n-1 of
// the row go past (last flag on cell n-1), and finally updates every inner cell
// in parallel from its two neighbors in the update state. Each item passes through
// accept, the full ring rotation and the update, whatever the rod length, as the
// rotation is set by the length of the cell ring; backpressure on the result side
// holds the rotation. The next item is taken once the update is done, even while the
// final result still waits in the output register. Cell count and conductivity are
// sampled when an item is accepted; end temperatures only enter the row on reload.
// After reset the row holds the reset register values (cell 31 is the right end).

module heat_rod_stencil_stepper (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input item: [0] restart, [7:1] zero
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [hrss_pkg::S_TD_W-1:0]   s_axis_tdata,
    // result item: [5:0] cell_position, [29:6] temperature,
    // [45:30] step_number, [47:46] zero
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [hrss_pkg::M_TD_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tlast,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hrss_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [hrss_pkg::DATA_W-1:0]   pwdata,
    output logic      [hrss_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import hrss_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROT,
        ST_UPD
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [STEP_W-1:0]   r_step;
    logic [N_W-1:0]      r_n;
    logic [COND_W-1:0]   r_k;

    // output register
    logic                r_ovalid;
    logic [POS_W-1:0]    r_opos;
    t_temp               r_otemp;
    logic [STEP_W-1:0]   r_ostep;
    logic                r_olast;

    t_cfg                w_cfg;
    t_cell_ctl           w_ctl;
    logic                w_accept;
    logic                w_restart;
    logic                w_emit;
    logic                w_adv;
    logic [N_W-1:0]      w_load_n;
    logic [COND_W-1:0]   w_k;
    logic signed [TFLD_W-1:0] w_ld_start;
    logic signed [TFLD_W-1:0] w_ld_left;
    logic signed [TFLD_W-1:0] w_ld_right;
    t_temp               w_temp [MAX_CELLS];

    hrss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_restart     = s_axis_tdata[0];

    // Emit only the first n positions of the rotation; advance when the slot is free or nothing is emitted
    assign w_emit = ({1'b0, r_cnt} < r_n);
    assign w_adv  = (r_state == ST_ROT) && (!w_emit || !r_ovalid || m_axis_tready);

    assign w_k = (w_cfg.cond > K_MAX) ? K_MAX : w_cfg.cond;

    // Load values come from the reset constants while reset is held
    assign w_load_n   = i_rst_n ? eff_cells(w_cfg.cells) : eff_cells(RST_CELLS);
    assign w_ld_start = i_rst_n ? w_cfg.start : RST_START;
    assign w_ld_left  = i_rst_n ? w_cfg.left  : RST_LEFT;
    assign w_ld_right = i_rst_n ? w_cfg.right : RST_RIGHT;

    assign w_ctl.load   = w_accept && w_restart;
    assign w_ctl.shift  = w_adv;
    assign w_ctl.update = (r_state == ST_UPD);

    // Ring of cells: each hands its value to the left neighbor, cell 0 wraps to the top
    for (genvar g = 0; g < MAX_CELLS; g++) begin : g_cell
        t_temp w_ld;
        logic  w_inner;

        assign w_inner = (g >= 1) && (N_W'(g) <= r_n - N_W'(2));

        always_comb begin
            if (g == 0) begin
                w_ld = sat_temp(SAT_W'(w_ld_left));
            end else if (N_W'(g) == w_load_n - N_W'(1)) begin
                w_ld = sat_temp(SAT_W'(w_ld_right));
            end else begin
                w_ld = sat_temp(SAT_W'(w_ld_start));
            end
        end

        hrss_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_inner    (w_inner),
            .i_k        (r_k),
            .i_load_val (w_ld),
            .i_prev     (w_temp[(g + MAX_CELLS - 1) % MAX_CELLS]),
            .i_next     (w_temp[(g + 1) % MAX_CELLS]),
            .o_temp     (w_temp[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_step   <= '0;
            r_n      <= eff_cells(RST_CELLS);
            r_k      <= RST_COND;
            r_ovalid <= 1'b0;
        end else begin
            // drop the held result once taken; a new result below overrides
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_n     <= eff_cells(w_cfg.cells);
                        r_k     <= w_k;
                        r_cnt   <= '0;
                        if (w_restart) begin
                            r_step <= '0;
                        end
                        r_state <= ST_ROT;
                    end
                end
                ST_ROT: begin
                    if (w_adv) begin
                        if (w_emit) begin
                            r_ovalid <= 1'b1;
                            r_opos   <= POS_W'(r_cnt);
                            r_otemp  <= w_temp[0];
                            r_ostep  <= r_step;
                            r_olast  <= ({1'b0, r_cnt} == r_n - N_W'(1));
                        end
                        r_cnt <= r_cnt + CNT_W'(1);
                        if (r_cnt == CNT_W'(MAX_CELLS - 1)) begin
                            r_state <= ST_UPD;
                        end
                    end
                end
                ST_UPD: begin
                    r_step  <= r_step + STEP_W'(1);
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {2'b00, r_ostep, TFLD_W'(r_otemp), r_opos};

    // Every accepted item starts a rotation from position zero
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_ROT) && (r_cnt == '0))
        else $error("accepted item did not start a rotation at zero");

    // A restart zeroes the step counter for the emitted row
    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_restart |=> (r_step == '0))
        else $error("restart did not clear the step counter");

    // The update cycle advances the step counter by one
    a_step_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |=> (r_step == $past(r_step) + STEP_W'(1)))
        else $error("step counter did not advance on update");

    // Results are produced only during the rotation
    a_emit_in_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_ROT))
        else $error("result produced outside the rotation");

endmodule

`default_nettype wire
